// File: hw/rtl/wdsd_pkg.sv
// Package for the windowed delta standard-deviation level classifier.
// Holds field widths, register indexes, level codes and the sequencer state type.
// No dependencies.
package wdsd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int DIFF_W   = 13;
    localparam int DEV_W    = 17;
    localparam int LEVEL_W  = 3;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W  = 11;

    // The scaled variance (num * 256) / (N * (N - 1)) stays below 2^34 for any
    // window, so its floor square root fits 17 bits and takes 17 steps.
    localparam int QUOT_W      = 34;
    localparam int DEV_MAX     = 131071;
    localparam int COUNT_MAX   = 2047;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODERATE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEAVY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIOLENT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd4;

    localparam logic [LEVEL_W-1:0] LEVEL_NONE     = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LIGHT    = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MODERATE = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_HEAVY    = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_VIOLENT  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_NEW,
        ST_SQ_OLD,
        ST_MAG,
        ST_NS2,
        ST_SQRT,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/wdsd_in_if.sv
// Sample channel of the windowed delta standard-deviation level classifier.
// Carries valid, ready and one 12-bit sample. Depends on wdsd_pkg.
interface wdsd_in_if;
    logic                          valid;
    logic                          ready;
    logic [wdsd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: hw/rtl/wdsd_out_if.sv
// Result channel of the windowed delta standard-deviation level classifier.
// Carries valid, ready, deviation and level. Depends on wdsd_pkg.
interface wdsd_out_if;
    logic                         valid;
    logic                         ready;
    logic [wdsd_pkg::DEV_W-1:0]   deviation;
    logic [wdsd_pkg::LEVEL_W-1:0] level;

    modport source (output valid, output deviation, output level, input ready);
    modport sink   (input valid, input deviation, input level, output ready);
endinterface

// File: hw/rtl/windowed_delta_stddev_level_classifier_top.sv
// Windowed delta standard-deviation level classifier, top level.
// Depends on wdsd_pkg, wdsd_in_if and wdsd_out_if.
//
//   channel       dir  payload                         handshake
//   i_sample_ch   in   sample[11:0]                    valid/ready
//   o_result_ch   out  deviation[16:0], level[2:0]     valid/ready
//   i_cfg_*       in   idx[2:0], data[16:0]            write enable only
//
// Sequence: the priming sample only loads the previous value; a sample without
// a report passes READ, SQ_NEW and SQ_OLD; a reporting sample goes on through
// MAG, NS2, the one-bit-per-cycle square root and DONE. Each root step compares
// N*(N-1)*root^2 with the scaled numerator; the division needs no state of its own.
// Reset: synchronous, active low; clears the window state and sums, loads the
// default thresholds. The window memory is not cleared: until the window first
// wraps, the entry being overwritten reads as zero.
// Stalls: a finished result waits in the output register; the sample channel
// is ready in idle even then. A new result waits in its last step until the
// output register is free.
module windowed_delta_stddev_level_classifier_top #(
    parameter int WINDOW = 128
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    wdsd_in_if.sink                        i_sample_ch,
    wdsd_out_if.source                     o_result_ch,
    input  logic                           i_cfg_we,
    input  logic [wdsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wdsd_pkg::CFG_W-1:0]     i_cfg_data
);

    // Widths that follow from the window depth.
    localparam int AW    = $clog2(WINDOW);          // window address
    localparam int LW    = $clog2(WINDOW);          // growth of sums
    localparam int NW    = $clog2(WINDOW + 1);      // holds N itself
    localparam int SW    = wdsd_pkg::DIFF_W + LW;   // signed running sum
    localparam int MAGW  = wdsd_pkg::SAMPLE_W + LW; // |sum|
    localparam int S2W   = 2 * wdsd_pkg::SAMPLE_W + LW; // sum of squares
    localparam int PW    = S2W + MAGW;              // multiplier product
    localparam int NUMW  = S2W + NW;                // N*S2 - S*S
    localparam int DVW   = NUMW + 8;                // numerator scaled by 256
    localparam int QW    = wdsd_pkg::QUOT_W;
    localparam longint unsigned DEN = longint'(WINDOW) * longint'(WINDOW - 1);
    localparam int DENW  = $clog2(DEN + 1);
    localparam int XW    = DENW + QW;               // DEN * root^2 and scaled numerator

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [wdsd_pkg::DEV_W-1:0]   r_thr_light;
    logic [wdsd_pkg::DEV_W-1:0]   r_thr_moderate;
    logic [wdsd_pkg::DEV_W-1:0]   r_thr_heavy;
    logic [wdsd_pkg::DEV_W-1:0]   r_thr_violent;
    logic [wdsd_pkg::COUNT_W-1:0] r_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_light    <= wdsd_pkg::DEV_W'(16);
            r_thr_moderate <= wdsd_pkg::DEV_W'(64);
            r_thr_heavy    <= wdsd_pkg::DEV_W'(256);
            r_thr_violent  <= wdsd_pkg::DEV_W'(1024);
            r_interval     <= wdsd_pkg::COUNT_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wdsd_pkg::REG_LIGHT:    r_thr_light    <= i_cfg_data;
                wdsd_pkg::REG_MODERATE: r_thr_moderate <= i_cfg_data;
                wdsd_pkg::REG_HEAVY:    r_thr_heavy    <= i_cfg_data;
                wdsd_pkg::REG_VIOLENT:  r_thr_violent  <= i_cfg_data;
                wdsd_pkg::REG_INTERVAL: r_interval     <= i_cfg_data[wdsd_pkg::COUNT_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------------
    wdsd_pkg::t_state r_state, n_state;

    logic                             r_primed;
    logic [wdsd_pkg::SAMPLE_W-1:0]    r_prev;
    logic signed [wdsd_pkg::DIFF_W-1:0] r_d;
    logic signed [wdsd_pkg::DIFF_W-1:0] r_old;
    logic [AW-1:0]                    r_wpos;
    logic                             r_full;
    logic signed [SW-1:0]             r_sum;
    logic [S2W-1:0]                   r_s2;
    logic [wdsd_pkg::COUNT_W-1:0]     r_since;
    logic [PW-1:0]                    r_prod;
    logic [NUMW-1:0]                  r_ssq;
    logic [XW-1:0]                    r_x;     // scaled numerator
    logic [XW-1:0]                    r_p;     // DEN * root^2 so far
    logic [XW-1:0]                    r_qsh;   // DEN * root, aligned to the current bit
    logic [XW-1:0]                    r_dsh;   // DEN * bit^2
    logic [wdsd_pkg::DEV_W-1:0]       r_res;
    logic [wdsd_pkg::DEV_W-1:0]       r_bit;

    logic                             r_out_valid;
    logic [wdsd_pkg::DEV_W-1:0]       r_out_dev;
    logic [wdsd_pkg::LEVEL_W-1:0]     r_out_level;

    // Window memory: one write and one registered read per cycle.
    logic [wdsd_pkg::DIFF_W-1:0]      r_window [WINDOW];
    logic [wdsd_pkg::DIFF_W-1:0]      r_rd;

    logic in_accept;
    logic mem_re;
    logic mem_we;
    logic load_out;

    assign in_accept = i_sample_ch.valid && i_sample_ch.ready;
    assign mem_re    = in_accept && r_primed;
    assign mem_we    = (r_state == wdsd_pkg::ST_READ);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_window[r_wpos] <= r_d;
        end
        if (mem_re) begin
            r_rd <= r_window[r_wpos];
        end
    end

    // ---------------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------------
    logic signed [wdsd_pkg::DIFF_W-1:0] new_diff;
    logic signed [wdsd_pkg::DIFF_W-1:0] old_val;
    logic [wdsd_pkg::DIFF_W-1:0]        d_abs;
    logic [wdsd_pkg::DIFF_W-1:0]        old_abs;
    logic [SW-1:0]                      sum_abs;
    logic [wdsd_pkg::COUNT_W-1:0]       since_next;
    logic [NUMW-1:0]                    num;
    logic [DVW-1:0]                     dividend;
    logic [XW-1:0]                      sq_trial;
    logic                               sq_ge;
    logic [wdsd_pkg::DEV_W-1:0]         dev;
    logic [wdsd_pkg::LEVEL_W-1:0]       level;
    logic [S2W-1:0]                     mul_a;
    logic [MAGW-1:0]                    mul_b;

    assign new_diff = $signed({1'b0, i_sample_ch.sample}) - $signed({1'b0, r_prev});
    // Before the first wrap the overwritten entry was never written: it is zero.
    assign old_val  = r_full ? $signed(r_rd) : '0;
    assign d_abs    = r_d[wdsd_pkg::DIFF_W-1]   ? wdsd_pkg::DIFF_W'(-r_d)   : r_d;
    assign old_abs  = r_old[wdsd_pkg::DIFF_W-1] ? wdsd_pkg::DIFF_W'(-r_old) : r_old;
    assign sum_abs  = r_sum[SW-1] ? SW'(-r_sum) : r_sum;

    assign since_next = (r_since == wdsd_pkg::COUNT_W'(wdsd_pkg::COUNT_MAX))
                        ? r_since : r_since + 1'b1;

    // N*S2 - S*S is never negative.
    assign num      = r_prod[NUMW-1:0] - r_ssq;
    assign dividend = {num, 8'b0};

    // Trial DEN * (root + bit)^2; keep the bit when it does not exceed the
    // scaled numerator, which gives floor(sqrt(floor(numerator / DEN))).
    assign sq_trial  = r_p + r_qsh + r_dsh;
    assign sq_ge     = (sq_trial <= r_x);

    // The root stays below 2^17, so it never exceeds the saturation limit.
    assign dev = r_res;

    // Highest threshold met wins, whatever their order.
    always_comb begin
        if (dev >= r_thr_violent) begin
            level = wdsd_pkg::LEVEL_VIOLENT;
        end else if (dev >= r_thr_heavy) begin
            level = wdsd_pkg::LEVEL_HEAVY;
        end else if (dev >= r_thr_moderate) begin
            level = wdsd_pkg::LEVEL_MODERATE;
        end else if (dev >= r_thr_light) begin
            level = wdsd_pkg::LEVEL_LIGHT;
        end else begin
            level = wdsd_pkg::LEVEL_NONE;
        end
    end

    // Shared multiplier operand select: d^2, old^2, S^2, then N*S2.
    always_comb begin
        case (r_state)
            wdsd_pkg::ST_READ: begin
                mul_a = S2W'(d_abs);
                mul_b = MAGW'(d_abs);
            end
            wdsd_pkg::ST_SQ_NEW: begin
                mul_a = S2W'(old_abs);
                mul_b = MAGW'(old_abs);
            end
            wdsd_pkg::ST_SQ_OLD: begin
                mul_a = S2W'(sum_abs);
                mul_b = MAGW'(sum_abs);
            end
            wdsd_pkg::ST_MAG: begin
                mul_a = r_s2;
                mul_b = MAGW'(WINDOW);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(mul_a) * PW'(mul_b);
    end

    // ---------------------------------------------------------------------
    // State register and next-state logic
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wdsd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            wdsd_pkg::ST_IDLE: begin
                if (in_accept && r_primed) begin
                    n_state = wdsd_pkg::ST_READ;
                end
            end
            wdsd_pkg::ST_READ:   n_state = wdsd_pkg::ST_SQ_NEW;
            wdsd_pkg::ST_SQ_NEW: n_state = wdsd_pkg::ST_SQ_OLD;
            wdsd_pkg::ST_SQ_OLD: begin
                if (r_full && (r_since >= r_interval)) begin
                    n_state = wdsd_pkg::ST_MAG;
                end else begin
                    n_state = wdsd_pkg::ST_IDLE;
                end
            end
            wdsd_pkg::ST_MAG: n_state = wdsd_pkg::ST_NS2;
            wdsd_pkg::ST_NS2: n_state = wdsd_pkg::ST_SQRT;
            wdsd_pkg::ST_SQRT: begin
                if (r_bit[0]) begin
                    n_state = wdsd_pkg::ST_DONE;
                end
            end
            wdsd_pkg::ST_DONE: begin
                // Hold until the output register is free or being emptied.
                if (!r_out_valid || o_result_ch.ready) begin
                    load_out = 1'b1;
                    n_state  = wdsd_pkg::ST_IDLE;
                end
            end
            default: n_state = wdsd_pkg::ST_IDLE;
        endcase
    end

    assign i_sample_ch.ready = (r_state == wdsd_pkg::ST_IDLE);

    // ---------------------------------------------------------------------
    // Window state: previous sample, sums, write position, report counter
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
            r_prev   <= '0;
            r_wpos   <= '0;
            r_full   <= 1'b0;
            r_sum    <= '0;
            r_s2     <= '0;
            r_since  <= '0;
        end else begin
            case (r_state)
                wdsd_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        r_primed <= 1'b1;
                        r_prev   <= i_sample_ch.sample;
                    end
                end
                wdsd_pkg::ST_READ: begin
                    r_sum   <= r_sum + SW'(r_d) - SW'(old_val);
                    r_since <= since_next;
                    if (r_wpos == AW'(WINDOW - 1)) begin
                        r_wpos <= '0;
                        r_full <= 1'b1;
                    end else begin
                        r_wpos <= r_wpos + 1'b1;
                    end
                end
                wdsd_pkg::ST_SQ_NEW: r_s2 <= r_s2 + r_prod[S2W-1:0];
                wdsd_pkg::ST_SQ_OLD: begin
                    r_s2 <= r_s2 - r_prod[S2W-1:0];
                    if (r_full && (r_since >= r_interval)) begin
                        r_since <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Difference capture and square-root iterations (payload only)
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            wdsd_pkg::ST_IDLE: begin
                if (in_accept) begin
                    r_d <= new_diff;
                end
            end
            wdsd_pkg::ST_READ: r_old <= old_val;
            wdsd_pkg::ST_MAG:  r_ssq <= r_prod[NUMW-1:0];
            wdsd_pkg::ST_NS2: begin
                // Start at the top root bit with an empty root.
                r_x   <= XW'(dividend);
                r_p   <= '0;
                r_qsh <= '0;
                r_dsh <= XW'(DEN) << (2 * (wdsd_pkg::DEV_W - 1));
                r_res <= '0;
                r_bit <= wdsd_pkg::DEV_W'(1) << (wdsd_pkg::DEV_W - 1);
            end
            wdsd_pkg::ST_SQRT: begin
                // One root bit per step; realign the partial terms to the next bit.
                if (sq_ge) begin
                    r_p   <= sq_trial;
                    r_qsh <= (r_qsh >> 1) + r_dsh;
                    r_res <= r_res | r_bit;
                end else begin
                    r_qsh <= r_qsh >> 1;
                end
                r_dsh <= r_dsh >> 2;
                r_bit <= r_bit >> 1;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_dev   <= dev;
            r_out_level <= level;
        end
    end

    assign o_result_ch.valid     = r_out_valid;
    assign o_result_ch.deviation = r_out_dev;
    assign o_result_ch.level     = r_out_level;

endmodule

// File: tb/sv/tb_windowed_delta_stddev_level_classifier_top.sv
`timescale 1ns / 1ps
// Testbench for windowed_delta_stddev_level_classifier_top: feeds sample transactions,
// predicts every report from its own window of differences and checks each result.
// Depends on wdsd_pkg, wdsd_in_if, wdsd_out_if and the top-level RTL.
module tb_windowed_delta_stddev_level_classifier_top;

    localparam int     WINDOW      = 128;
    localparam int     CLK_HALF    = 5;
    localparam int     SAMPLE_MAX  = (1 << wdsd_pkg::SAMPLE_W) - 1;
    localparam int     MAX_IDLE    = 17;
    localparam int     LONG_HOLD   = 400;
    // Long enough for a reporting sample to finish, with margin on top of that.
    localparam int     SETTLE_CYC  = 80;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [wdsd_pkg::DEV_W-1:0]   deviation;
        logic [wdsd_pkg::LEVEL_W-1:0] level;
    } t_report;

    typedef enum int {
        SHAPE_UNIFORM,
        SHAPE_WALK,
        SHAPE_FLAT,
        SHAPE_SWING,
        SHAPE_SPIKE
    } t_shape;

    // ------------------------------------------------------------------
    // Stimulus-side signals, all known from time zero
    // ------------------------------------------------------------------
    logic                           i_clk     = 1'b0;
    logic                           i_rst_n   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [wdsd_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [wdsd_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           smp_valid = 1'b0;
    logic [wdsd_pkg::SAMPLE_W-1:0]  smp_value = '0;
    logic                           res_ready = 1'b0;

    wdsd_in_if  sample_ch ();
    wdsd_out_if result_ch ();

    assign sample_ch.valid  = smp_valid;
    assign sample_ch.sample = smp_value;
    assign result_ch.ready  = res_ready;

    windowed_delta_stddev_level_classifier_top #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_ch (sample_ch),
        .o_result_ch (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial forever #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: configuration and window, at their reset values
    // ------------------------------------------------------------------
    logic [wdsd_pkg::DEV_W-1:0]    thr_light       = 17'd16;
    logic [wdsd_pkg::DEV_W-1:0]    thr_moderate    = 17'd64;
    logic [wdsd_pkg::DEV_W-1:0]    thr_heavy       = 17'd256;
    logic [wdsd_pkg::DEV_W-1:0]    thr_violent     = 17'd1024;
    logic [wdsd_pkg::COUNT_W-1:0]  report_interval = 11'd10;

    logic [wdsd_pkg::SAMPLE_W-1:0] last_sample  = '0;
    bit                            primed       = 1'b0;
    int                            diff_ring [WINDOW] = '{default: 0};
    int                            ring_pos     = 0;
    bit                            ring_full    = 1'b0;
    longint                        delta_sum    = 0;
    longint unsigned               delta_sq_sum = 0;
    int                            since_report = 0;

    t_report                       expected_reports [$];
    logic [wdsd_pkg::SAMPLE_W-1:0] pending_samples [$];
    logic [wdsd_pkg::SAMPLE_W-1:0] edge_samples [16] = '{
        12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd2047,
        12'd1, 12'd4094, 12'hAAA, 12'h555, 12'hFFF, 12'h800, 12'h7FF, 12'd0
    };
    logic [wdsd_pkg::SAMPLE_W-1:0] gen_value = '0;

    // Handshake bookkeeping; each counter has exactly one writer.
    int  samples_offered = 0;
    int  samples_taken   = 0;
    int  reports_taken   = 0;
    int  reports_seen    = 0;
    int  holds_requested = 0;
    int  holds_served    = 0;
    int  fail_count      = 0;

    bit  offering  = 1'b0;
    bit  send_idle = 1'b1;
    int  send_gap  = 0;
    bit  recv_idle = 1'b1;
    int  recv_gap  = 0;
    int  hold_left = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Integer square root, floor, bit-pair method.
    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned root = 0;
        longint unsigned probe = 64'd1 << 62;
        while (probe > x) probe >>= 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Sample std deviation of the window in Q.4: floor(16*sqrt(var)), divisor N-1.
    function automatic logic [wdsd_pkg::DEV_W-1:0] window_stddev_q4();
        longint unsigned n = WINDOW;
        longint unsigned mag;
        longint unsigned root;
        mag  = (delta_sum < 0) ? -delta_sum : delta_sum;
        root = floor_sqrt(((n * delta_sq_sum - mag * mag) * 256) / (n * (n - 1)));
        if (root > wdsd_pkg::DEV_MAX) root = wdsd_pkg::DEV_MAX;
        return root[wdsd_pkg::DEV_W-1:0];
    endfunction

    // Highest threshold met wins, whatever order the thresholds are in.
    function automatic logic [wdsd_pkg::LEVEL_W-1:0] classify_level(
        logic [wdsd_pkg::DEV_W-1:0] dev
    );
        if (dev >= thr_violent)       return wdsd_pkg::LEVEL_VIOLENT;
        else if (dev >= thr_heavy)    return wdsd_pkg::LEVEL_HEAVY;
        else if (dev >= thr_moderate) return wdsd_pkg::LEVEL_MODERATE;
        else if (dev >= thr_light)    return wdsd_pkg::LEVEL_LIGHT;
        return wdsd_pkg::LEVEL_NONE;
    endfunction

    // Advance the window by one accepted sample; queue a report when one is due.
    function automatic void absorb_sample(logic [wdsd_pkg::SAMPLE_W-1:0] s);
        int      d;
        int      old;
        t_report rep;
        // The first sample only primes the previous value.
        if (!primed) begin
            primed      = 1'b1;
            last_sample = s;
            return;
        end
        d           = int'(s) - int'(last_sample);
        last_sample = s;
        old                 = diff_ring[ring_pos];
        diff_ring[ring_pos] = d;
        delta_sum           = delta_sum + d - old;
        delta_sq_sum        = delta_sq_sum + longint'(d * d) - longint'(old * old);
        ring_pos++;
        if (ring_pos >= WINDOW) begin
            ring_pos  = 0;
            ring_full = 1'b1;
        end
        // Count differences, saturating, so any interval is honored.
        if (since_report < wdsd_pkg::COUNT_MAX) since_report++;
        if (!ring_full || since_report < int'(report_interval)) return;
        since_report  = 0;
        rep.deviation = window_stddev_q4();
        rep.level     = classify_level(rep.deviation);
        expected_reports.push_back(rep);
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: change inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // Drop the offer once the monitor has seen it accepted.
            if (offering && samples_taken == samples_offered) offering = 1'b0;
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    smp_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    smp_value <= pending_samples.pop_front();
                    smp_valid <= 1'b1;
                    samples_offered++;
                    offering = 1'b1;
                    // Flip between idling and back-to-back stretches now and then.
                    if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
                    send_gap = send_idle ? $urandom_range(0, MAX_IDLE) : 0;
                end else begin
                    smp_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls per transaction, plus long holds on request
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (holds_served != holds_requested) begin
                holds_served = holds_requested;
                hold_left    = LONG_HOLD;
            end
            if (reports_seen != reports_taken) begin
                reports_seen = reports_taken;
                if ($urandom_range(0, 15) == 0) recv_idle = !recv_idle;
                recv_gap = recv_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                res_ready <= 1'b0;
            end else begin
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_report got;
        t_report want;
        if (i_rst_n) begin
            if (sample_ch.valid && sample_ch.ready) begin
                samples_taken++;
                absorb_sample(sample_ch.sample);
            end
            if (result_ch.valid && result_ch.ready) begin
                reports_taken++;
                got.deviation = result_ch.deviation;
                got.level     = result_ch.level;
                if (expected_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with none expected, deviation %0d level %0d",
                             $time, got.deviation, got.level);
                end else begin
                    want = expected_reports.pop_front();
                    if (got.deviation !== want.deviation) begin
                        fail_count++;
                        $display("%0t: deviation mismatch, expected %0d, actual %0d",
                                 $time, want.deviation, got.deviation);
                    end
                    if (got.level !== want.level) begin
                        fail_count++;
                        $display("%0t: level mismatch, expected %0d, actual %0d",
                                 $time, want.level, got.level);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Write one register at a falling edge; hold enable for one rising edge.
    task automatic program_register(logic [wdsd_pkg::CFG_IDX_W-1:0] idx,
                                    logic [wdsd_pkg::CFG_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            wdsd_pkg::REG_LIGHT:    thr_light       = value[wdsd_pkg::DEV_W-1:0];
            wdsd_pkg::REG_MODERATE: thr_moderate    = value[wdsd_pkg::DEV_W-1:0];
            wdsd_pkg::REG_HEAVY:    thr_heavy       = value[wdsd_pkg::DEV_W-1:0];
            wdsd_pkg::REG_VIOLENT:  thr_violent     = value[wdsd_pkg::DEV_W-1:0];
            wdsd_pkg::REG_INTERVAL: report_interval = value[wdsd_pkg::COUNT_W-1:0];
            default:      ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_thresholds(int lt, int mt, int ht, int vt);
        program_register(wdsd_pkg::REG_LIGHT,    wdsd_pkg::CFG_W'(lt));
        program_register(wdsd_pkg::REG_MODERATE, wdsd_pkg::CFG_W'(mt));
        program_register(wdsd_pkg::REG_HEAVY,    wdsd_pkg::CFG_W'(ht));
        program_register(wdsd_pkg::REG_VIOLENT,  wdsd_pkg::CFG_W'(vt));
    endtask

    // Queue bursts of shaped signal: noise, random walks, flat runs, full swings
    // and flat runs with spikes, so the deviation sweeps across all levels.
    task automatic queue_samples(int count);
        t_shape shape;
        int     run;
        int     step;
        int     v;
        while (count > 0) begin
            shape = t_shape'($urandom_range(0, 4));
            run   = $urandom_range(4, 60);
            if (run > count) run = count;
            step  = 1 << (2 * $urandom_range(0, 5));
            repeat (run) begin
                case (shape)
                    SHAPE_UNIFORM: v = $urandom_range(0, SAMPLE_MAX);
                    SHAPE_WALK:    v = int'(gen_value) + int'($urandom_range(0, 2 * step)) - step;
                    SHAPE_FLAT:    v = int'(gen_value);
                    SHAPE_SWING:   v = gen_value[wdsd_pkg::SAMPLE_W-1] ? 0 : SAMPLE_MAX;
                    default:       v = ($urandom_range(0, 7) == 0) ?
                                       int'($urandom_range(0, SAMPLE_MAX)) : int'(gen_value);
                endcase
                if (v < 0) v = 0;
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                gen_value = v[wdsd_pkg::SAMPLE_W-1:0];
                pending_samples.push_back(gen_value);
            end
            count -= run;
        end
    endtask

    // Wait until every queued sample is accepted and every report checked, then
    // let a full report latency pass so the block is idle.
    task automatic settle();
        while (pending_samples.size() != 0 || samples_taken != samples_offered ||
               expected_reports.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Cycle limit
    // ------------------------------------------------------------------
    initial begin : watchdog
        longint cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        int lt;
        int mt;
        int ht;
        int vt;
        int k;

        // Hold reset active from time zero, then release it on a falling edge.
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Long interval straight from reset: the window fill alone must not
        // trigger a report; reports land on the 200th and 400th differences.
        program_register(wdsd_pkg::REG_INTERVAL, wdsd_pkg::CFG_W'(200));
        // Field extremes and full-scale differences; the first one only primes.
        foreach (edge_samples[i]) pending_samples.push_back(edge_samples[i]);
        gen_value = edge_samples[15];
        queue_samples(420);
        settle();

        // Writes to unused indexes must leave every register alone.
        for (k = 1; k <= 3; k++)
            program_register(wdsd_pkg::REG_INTERVAL + wdsd_pkg::CFG_IDX_W'(k),
                             wdsd_pkg::CFG_W'($urandom));

        // All thresholds zero, interval zero: every difference reports violent.
        // Hold the result side off long enough that the block backs up and
        // stalls the sample side.
        program_thresholds(0, 0, 0, 0);
        program_register(wdsd_pkg::REG_INTERVAL, wdsd_pkg::CFG_W'(0));
        holds_requested++;
        queue_samples(60);
        settle();

        // All thresholds at full scale, interval one with upper data bits set.
        program_thresholds(wdsd_pkg::DEV_MAX, wdsd_pkg::DEV_MAX,
                           wdsd_pkg::DEV_MAX, wdsd_pkg::DEV_MAX);
        program_register(wdsd_pkg::REG_INTERVAL, {6'h3F, 11'd1});
        queue_samples(40);
        settle();

        // Thresholds out of order: the highest level met still wins.
        program_thresholds(40000, 20000, 8000, 2000);
        program_register(wdsd_pkg::REG_INTERVAL, wdsd_pkg::CFG_W'(2));
        queue_samples(80);
        settle();

        // Random settings, mostly ascending thresholds across the usual range.
        repeat (4) begin
            if ($urandom_range(0, 3) != 0) begin
                lt = $urandom_range(0, 8000);
                mt = lt + $urandom_range(0, 10000);
                ht = mt + $urandom_range(0, 10000);
                vt = ht + $urandom_range(0, 10000);
            end else begin
                lt = $urandom_range(0, 40000);
                mt = $urandom_range(0, 40000);
                ht = $urandom_range(0, 40000);
                vt = $urandom_range(0, 40000);
            end
            program_thresholds(lt, mt, ht, vt);
            program_register(wdsd_pkg::REG_INTERVAL,
                             {6'($urandom_range(0, 63)), 11'($urandom_range(1, 20))});
            queue_samples(80);
            settle();
        end

        if (fail_count == 0 && expected_reports.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
